/* rtl/core/variable_frame_receiver_macros.svh */
// assertion macros for the variable frame receiver
// no dependencies; empty in synthesis builds
`ifndef VARIABLE_FRAME_RECEIVER_MACROS_SVH
`define VARIABLE_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
`define VFR_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vfr assertion failed");
`define VFR_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("vfr assertion failed");
`else
`define VFR_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define VFR_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

/* rtl/core/vfr_pkg.sv */
// shared types and constants of the variable frame receiver
// no dependencies
package vfr_pkg;

    localparam int unsigned ADDR_W = 4;

    localparam logic [1:0] REG_MAX_LENGTH = 2'd0;
    localparam logic [1:0] REG_START_CODE = 2'd1;
    localparam logic [1:0] REG_END_CODE   = 2'd2;

    localparam logic [7:0] MAX_LENGTH_RST = 8'hFF;
    localparam logic [7:0] START_CODE_RST = 8'h68;
    localparam logic [7:0] END_CODE_RST   = 8'h16;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_BAD      = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    typedef struct packed {
        logic [7:0] max_length;
        logic [7:0] start_code;
        logic [7:0] end_code;
    } vfr_cfg_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [7:0]  frame_length;
        logic [7:0]  position;
        logic [31:0] good_frames;
        logic [31:0] bytes_seen;
    } vfr_result_t;

endpackage

/* rtl/core/vfr_deframer.sv */
// frame parsing state machine with byte and good-frame counters
// depends on vfr_pkg
module vfr_deframer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    input  vfr_pkg::vfr_cfg_t    cfg,
    output vfr_pkg::vfr_result_t res
);
    import vfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_REPEAT,
        PH_START2,
        PH_DATA,
        PH_CHECK,
        PH_END
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic [7:0]  declared_reg, declared_next;
    logic [7:0]  checksum_reg, checksum_next;
    logic [31:0] frame_cnt_reg, frame_cnt_next;
    logic [31:0] byte_cnt_reg, byte_cnt_next;

    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        declared_next  = declared_reg;
        checksum_next  = checksum_reg;
        frame_cnt_next = frame_cnt_reg;
        byte_cnt_next  = byte_cnt_reg + 32'd1;

        res              = '0;
        res.kind         = KIND_DATA;
        res.value        = rx_byte;
        res.frame_length = declared_reg;

        case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == cfg.start_code) begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                remaining_next = rx_byte;
                phase_next     = (rx_byte > cfg.max_length) ? PH_HUNT : PH_REPEAT;
            end
            PH_REPEAT: begin
                if (rx_byte != remaining_reg) begin
                    phase_next = PH_HUNT;
                end else begin
                    declared_next = remaining_reg;
                    phase_next    = PH_START2;
                end
            end
            PH_START2: begin
                if (rx_byte != cfg.start_code) begin
                    phase_next = PH_HUNT;
                end else if (remaining_reg == 8'd0) begin
                    phase_next = PH_CHECK;
                end else begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                res.valid      = 1'b1;
                res.position   = declared_reg - remaining_reg;
                remaining_next = remaining_reg - 8'd1;
                if (remaining_reg == 8'd1) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                checksum_next = rx_byte;
                phase_next    = PH_END;
            end
            PH_END: begin
                res.valid = 1'b1;
                res.value = checksum_reg;
                if (rx_byte == cfg.end_code) begin
                    frame_cnt_next = frame_cnt_reg + 32'd1;
                    res.kind       = KIND_GOOD;
                end else begin
                    res.kind = KIND_BAD;
                end
                phase_next = PH_HUNT;
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase

        res.good_frames = frame_cnt_next;
        res.bytes_seen  = byte_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            remaining_reg <= '0;
            declared_reg  <= '0;
            checksum_reg  <= '0;
            frame_cnt_reg <= '0;
            byte_cnt_reg  <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            declared_reg  <= declared_next;
            checksum_reg  <= checksum_next;
            frame_cnt_reg <= frame_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
        end
    end

endmodule

/* rtl/core/variable_frame_receiver.sv */
// top level of the variable frame receiver: config registers, input and result registers
// depends on vfr_pkg, vfr_deframer and variable_frame_receiver_macros.svh
//
//   channel   ports                      direction  handshake
//   input     s_rx_byte                  in         s_valid / s_ready
//   result    m_kind .. m_bytes_seen     out        m_valid / m_ready
//   config    psel penable pwrite paddr  in         apb, pready tied high
//
// one beat per cycle unless m_ready stalls; a byte goes from input register to result register
// the parse state advances once per byte, in a single step between the two registers
// a stalled result register holds the byte in the input register; s_ready drops only then
// synchronous active-low reset returns to start hunting with counters cleared
`include "variable_frame_receiver_macros.svh"

module variable_frame_receiver (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [vfr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_rx_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_kind,
    output logic [7:0]                m_value,
    output logic [7:0]                m_frame_length,
    output logic [7:0]                m_position,
    output logic [31:0]               m_good_frames,
    output logic [31:0]               m_bytes_seen
);
    import vfr_pkg::*;

    vfr_cfg_t    cfg_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    vfr_result_t out_reg;
    vfr_result_t res;
    logic        advance;
    logic        cfg_wr;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_length <= MAX_LENGTH_RST;
            cfg_reg.start_code <= START_CODE_RST;
            cfg_reg.end_code   <= END_CODE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MAX_LENGTH: cfg_reg.max_length <= pwdata[7:0];
                REG_START_CODE: cfg_reg.start_code <= pwdata[7:0];
                REG_END_CODE:   cfg_reg.end_code   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_LENGTH: prdata = {24'd0, cfg_reg.max_length};
            REG_START_CODE: prdata = {24'd0, cfg_reg.start_code};
            REG_END_CODE:   prdata = {24'd0, cfg_reg.end_code};
            default:        prdata = '0;
        endcase
    end

    // the held byte moves on whenever the result register is free or being emptied
    assign advance = in_valid_reg && (!out_reg.valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    vfr_deframer u_deframer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (advance) begin
            out_reg <= res;
        end else if (m_ready) begin
            out_reg.valid <= 1'b0;
        end
    end

    assign m_valid        = out_reg.valid;
    assign m_kind         = out_reg.kind;
    assign m_value        = out_reg.value;
    assign m_frame_length = out_reg.frame_length;
    assign m_position     = out_reg.position;
    assign m_good_frames  = out_reg.good_frames;
    assign m_bytes_seen   = out_reg.bytes_seen;

    `VFR_ASSERT_NEVER(a_kind_legal, aclk, aresetn, m_valid && m_kind == KIND_RESERVED)
    `VFR_ASSERT_IMPLIES(a_end_pos_zero, aclk, aresetn, m_valid && m_kind != KIND_DATA, m_position == 8'd0)
    `VFR_ASSERT_IMPLIES(a_pos_in_frame, aclk, aresetn, m_valid && m_kind == KIND_DATA, m_position < m_frame_length)
    `VFR_ASSERT_IMPLIES(a_stall_held, aclk, aresetn, !s_ready, in_valid_reg && m_valid && !m_ready)

endmodule
